### hw/rtl/life_generation_torus_core_defines.svh
// Assertion macros for the life generation torus core.
`ifndef LIFE_GENERATION_TORUS_CORE_DEFINES_SVH
`define LIFE_GENERATION_TORUS_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define LGT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lgt assertion failed");
`define LGT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lgt assertion failed");
`else
`define LGT_ASSERT_IMP(lbl, ante, cons)
`define LGT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### hw/rtl/lgt_pkg.sv
// Shared constants, types and the cell rule for the life generation torus core.
package lgt_pkg;

    localparam int ROWS   = 16;
    localparam int COLS   = 32;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int CNT_W  = ROW_W + 1;
    localparam int IDX_W  = 4;
    localparam int CELL_W = 32;
    localparam int IN_W   = ((IDX_W + CELL_W + 7) / 8) * 8;
    localparam int OUT_W  = ((IDX_W + CELL_W + 7) / 8) * 8;

    typedef logic [COLS-1:0]  row_t;
    typedef logic [ROW_W-1:0] ridx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic {
        FUNC_WRITE   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    localparam cnt_t CNT_ROWS = CNT_W'(ROWS);
    localparam cnt_t CNT_LAST = CNT_W'(ROWS + 1);

    typedef struct packed {
        logic  we;
        ridx_t waddr;
        row_t  wdata;
    } grid_wr_t;

    typedef struct packed {
        logic done;
        logic same;
    } sweep_st_t;

    function automatic row_t life_row(input row_t up, input row_t mid, input row_t dn);
        row_t       res;
        logic [3:0] n;
        int         lf;
        int         rt;
        res = '0;
        for (int c = 0; c < COLS; c++) begin
            lf = (c == 0) ? COLS - 1 : c - 1;
            rt = (c == COLS - 1) ? 0 : c + 1;
            n = {3'b000, up[lf]} + {3'b000, up[c]} + {3'b000, up[rt]}
              + {3'b000, mid[lf]} + {3'b000, mid[rt]}
              + {3'b000, dn[lf]} + {3'b000, dn[c]} + {3'b000, dn[rt]};
            res[c] = (n == 4'd3) || (mid[c] && (n == 4'd2));
        end
        return res;
    endfunction

endpackage

### hw/rtl/lgt_sweep.sv
// Grid memory and generation sweep over a three-row window.
module lgt_sweep (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  lgt_pkg::grid_wr_t grid_wr,
    output lgt_pkg::grid_wr_t nxt_wr,
    output lgt_pkg::sweep_st_t st
);
    import lgt_pkg::*;

    row_t            grid_mem [ROWS];
    logic [ROWS-1:0] vld_reg;
    logic            active_reg, active_next;
    cnt_t            rd_cnt_reg, rd_cnt_next;
    logic            rdv_reg;
    cnt_t            seq_reg;
    row_t            q_reg;
    logic            qv_reg;
    row_t            up_reg, mid_reg;
    logic            same_reg, same_next;
    logic            done_reg, done_next;
    cnt_t            rd_prev;
    cnt_t            wr_seq;
    ridx_t           rd_addr;
    row_t            rd_row, new_row;
    logic            calc;

    always_comb
    begin
        rd_prev = rd_cnt_reg - cnt_t'(1);
        if (rd_cnt_reg == '0)
        begin
            rd_addr = ridx_t'(ROWS - 1);
        end
        else if (rd_cnt_reg == CNT_LAST)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = rd_prev[ROW_W-1:0];
        end
    end

    assign rd_row  = qv_reg ? q_reg : '0;
    assign calc    = rdv_reg && (seq_reg >= cnt_t'(2));
    assign new_row = life_row(up_reg, mid_reg, rd_row);
    assign wr_seq  = seq_reg - cnt_t'(2);

    assign nxt_wr.we    = calc;
    assign nxt_wr.waddr = wr_seq[ROW_W-1:0];
    assign nxt_wr.wdata = new_row;

    always_comb
    begin
        active_next = active_reg;
        rd_cnt_next = rd_cnt_reg;
        same_next   = same_reg;
        if (start)
        begin
            active_next = 1'b1;
            rd_cnt_next = '0;
            same_next   = 1'b1;
        end
        else
        begin
            if (active_reg)
            begin
                rd_cnt_next = rd_cnt_reg + cnt_t'(1);
                if (rd_cnt_reg == CNT_LAST)
                begin
                    active_next = 1'b0;
                end
            end
            if (calc && (new_row != mid_reg))
            begin
                same_next = 1'b0;
            end
        end
        done_next = rdv_reg && (seq_reg == CNT_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            active_reg <= 1'b0;
            rd_cnt_reg <= '0;
            rdv_reg    <= 1'b0;
            same_reg   <= 1'b1;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (grid_wr.we)
            begin
                vld_reg[grid_wr.waddr] <= 1'b1;
            end
            active_reg <= active_next;
            rd_cnt_reg <= rd_cnt_next;
            rdv_reg    <= active_reg;
            same_reg   <= same_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (grid_wr.we)
        begin
            grid_mem[grid_wr.waddr] <= grid_wr.wdata;
        end
        if (active_reg)
        begin
            q_reg  <= grid_mem[rd_addr];
            qv_reg <= vld_reg[rd_addr];
        end
        seq_reg <= rd_cnt_reg;
        if (rdv_reg)
        begin
            up_reg  <= mid_reg;
            mid_reg <= rd_row;
        end
    end

    assign st.done = done_reg;
    assign st.same = same_reg;

endmodule

### hw/rtl/lgt_emit.sv
// Next-generation memory, row emission and grid write-back.
module lgt_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  lgt_pkg::grid_wr_t nxt_wr,
    input  logic              start,
    input  logic              same_in,
    input  logic              m_ready,
    output logic              m_valid,
    output lgt_pkg::ridx_t    m_row,
    output lgt_pkg::row_t     m_cells,
    output logic              m_same,
    output logic              m_last,
    output lgt_pkg::grid_wr_t wb,
    output logic              done
);
    import lgt_pkg::*;

    row_t  nxt_mem [ROWS];
    logic  issuing_reg, issuing_next;
    cnt_t  iss_cnt_reg, iss_cnt_next;
    logic  q_valid_reg, q_valid_next;
    ridx_t q_row_reg;
    row_t  q_cells_reg;
    logic  same_reg;
    logic  out_valid_reg, out_valid_next;
    ridx_t out_row_reg;
    row_t  out_cells_reg;
    logic  out_same_reg;
    logic  out_last_reg;
    ridx_t iss_idx;
    logic  rd_en;
    logic  load;

    assign iss_idx = iss_cnt_reg[ROW_W-1:0];
    assign load    = q_valid_reg && (!out_valid_reg || m_ready);
    assign rd_en   = issuing_reg && (iss_cnt_reg != CNT_ROWS) && (!q_valid_reg || load);
    assign done    = issuing_reg && (iss_cnt_reg == CNT_ROWS) && !q_valid_reg;

    always_comb
    begin
        issuing_next   = issuing_reg;
        iss_cnt_next   = iss_cnt_reg;
        q_valid_next   = q_valid_reg;
        out_valid_next = out_valid_reg;
        if (start)
        begin
            issuing_next = 1'b1;
            iss_cnt_next = '0;
        end
        else if (done)
        begin
            issuing_next = 1'b0;
        end
        if (rd_en)
        begin
            iss_cnt_next = iss_cnt_reg + cnt_t'(1);
            q_valid_next = 1'b1;
        end
        else if (load)
        begin
            q_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issuing_reg   <= 1'b0;
            iss_cnt_reg   <= '0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            issuing_reg   <= issuing_next;
            iss_cnt_reg   <= iss_cnt_next;
            q_valid_reg   <= q_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nxt_wr.we)
        begin
            nxt_mem[nxt_wr.waddr] <= nxt_wr.wdata;
        end
        if (rd_en)
        begin
            q_cells_reg <= nxt_mem[iss_idx];
            q_row_reg   <= iss_idx;
        end
        if (start)
        begin
            same_reg <= same_in;
        end
        if (load)
        begin
            out_row_reg   <= q_row_reg;
            out_cells_reg <= q_cells_reg;
            out_same_reg  <= same_reg;
            out_last_reg  <= (q_row_reg == ridx_t'(ROWS - 1));
        end
    end

    assign wb.we    = load;
    assign wb.waddr = q_row_reg;
    assign wb.wdata = q_cells_reg;

    assign m_valid = out_valid_reg;
    assign m_row   = out_row_reg;
    assign m_cells = out_cells_reg;
    assign m_same  = out_same_reg;
    assign m_last  = out_last_reg;

endmodule

### hw/rtl/life_generation_torus_core.sv
// Top level of the toroidal life generation core.
//
//  channel  dir  tdata (low bit up)               tuser      tlast
//  s_*      in   row_index[3:0] row_cells[35:4]   func       -
//  m_*      out  out_row[3:0]   out_cells[35:4]   unchanged  last
//
// An advance reads the grid memory one row per cycle over ROWS+2 reads and hands
// off to emission when the sweep is done, then streams ROWS rows from the
// next-generation memory at one row per cycle while m_tready is high;
// s_tready returns when emission is done.
// Reset marks every grid row invalid; an invalid row reads as all dead.
// m_tready low holds the emission; s_tready is high only while idle.
module life_generation_torus_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [lgt_pkg::IN_W-1:0] s_tdata,   // row_index, row_cells, zero pad
    input  logic                     s_tuser,   // func
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [lgt_pkg::OUT_W-1:0] m_tdata,  // out_row, out_cells, zero pad
    output logic                     m_tuser,   // unchanged
    output logic                     m_tlast
);
    import lgt_pkg::*;

    `include "life_generation_torus_core_defines.svh"

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic                in_beat;
    logic [IDX_W-1:0]    row_index;
    logic [CELL_W-1:0]   row_cells;
    logic                sweep_start;
    grid_wr_t            grid_wr;
    grid_wr_t            nxt_wr;
    grid_wr_t            wb;
    sweep_st_t           sw_st;
    logic                emit_done;
    ridx_t               emit_row;
    row_t                emit_cells;
    logic                emit_same;
    logic                emit_last;
    logic                emit_valid;

    assign s_tready    = (state_reg == ST_IDLE);
    assign in_beat     = s_tvalid && s_tready;
    assign row_index   = s_tdata[IDX_W-1:0];
    assign row_cells   = s_tdata[IDX_W+CELL_W-1:IDX_W];
    assign sweep_start = in_beat && (s_tuser == FUNC_ADVANCE);

    always_comb
    begin
        if (state_reg == ST_EMIT)
        begin
            grid_wr = wb;
        end
        else
        begin
            grid_wr.we    = in_beat && (s_tuser == FUNC_WRITE) && (int'(row_index) < ROWS);
            grid_wr.waddr = row_index[ROW_W-1:0];
            grid_wr.wdata = row_cells[COLS-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sweep_start)
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (sw_st.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    lgt_sweep u_sweep (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sweep_start),
        .grid_wr (grid_wr),
        .nxt_wr  (nxt_wr),
        .st      (sw_st)
    );

    lgt_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .nxt_wr  (nxt_wr),
        .start   (sw_st.done),
        .same_in (sw_st.same),
        .m_ready (m_tready),
        .m_valid (emit_valid),
        .m_row   (emit_row),
        .m_cells (emit_cells),
        .m_same  (emit_same),
        .m_last  (emit_last),
        .wb      (wb),
        .done    (emit_done)
    );

    assign m_tvalid = emit_valid;
    assign m_tdata  = {{(OUT_W - IDX_W - CELL_W){1'b0}},
                       CELL_W'(emit_cells), IDX_W'(emit_row)};
    assign m_tuser  = emit_same;
    assign m_tlast  = emit_last;

    `LGT_ASSERT_NXT(a_adv_starts_sweep, sweep_start, state_reg == ST_SWEEP)
    `LGT_ASSERT_IMP(a_sweep_done_in_sweep, sw_st.done, state_reg == ST_SWEEP)
    `LGT_ASSERT_IMP(a_emit_done_in_emit, emit_done, state_reg == ST_EMIT)
    `LGT_ASSERT_IMP(a_writeback_in_emit, wb.we, state_reg == ST_EMIT)

endmodule

### verif/tb_top.sv
// Testbench for the toroidal life generation core: row writes, advances, stalls.
`timescale 1ns / 1ps

module tb_top;
    import lgt_pkg::*;

    typedef struct {
        ridx_t row;
        row_t  cells;
        logic  same;
        logic  last;
    } gen_row_t;

    localparam int LONG_HOLD  = 300;
    localparam int ITEM_COUNT = 200;
    localparam int MAX_PRINTS = 100;

    class torus_life_scoreboard;
        row_t     grid [ROWS];
        gen_row_t pending_rows [$];
        int       errors;

        function new();
            for (int r = 0; r < ROWS; r++)
                grid[r] = '0;
            errors = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_beat(func_t func, ridx_t idx, row_t cells);
            row_t     nxt [ROWS];
            int       n;
            bit       same;
            gen_row_t e;
            if (func == FUNC_WRITE)
            begin
                if (int'(idx) < ROWS)
                    grid[idx] = cells;
                return;
            end
            same = 1'b1;
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < COLS; c++)
                begin
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++)
                        for (int dc = -1; dc <= 1; dc++)
                            if (dr != 0 || dc != 0)
                                n += grid[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS];
                    nxt[r][c] = (n == 3) || (grid[r][c] && n == 2);
                end
                if (nxt[r] != grid[r])
                    same = 1'b0;
            end
            for (int r = 0; r < ROWS; r++)
            begin
                grid[r]  = nxt[r];
                e.row    = ridx_t'(r);
                e.cells  = nxt[r];
                e.same   = same;
                e.last   = (r == ROWS - 1);
                pending_rows.push_back(e);
            end
        endfunction

        task check_row(ridx_t row, row_t cells, logic same, logic last);
            gen_row_t e;
            if (pending_rows.size() == 0)
            begin
                report($sformatf("unexpected beat row %0d cells %h", row, cells));
                return;
            end
            e = pending_rows.pop_front();
            if (row !== e.row)
                report($sformatf("row index exp %0d got %0d", e.row, row));
            if (cells !== e.cells)
                report($sformatf("row %0d cells exp %h got %h", e.row, e.cells, cells));
            if (same !== e.same)
                report($sformatf("row %0d unchanged exp %b got %b", e.row, e.same, same));
            if (last !== e.last)
                report($sformatf("row %0d last exp %b got %b", e.row, e.last, last));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;   // row_index, row_cells, zero pad
    logic                s_tuser;   // func
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;   // out_row, out_cells, zero pad
    logic                m_tuser;   // unchanged
    logic                m_tlast;

    torus_life_scoreboard sb;
    bit hold_req = 1'b0;
    bit quiet    = 1'b0;
    int items    = 0;

    life_generation_torus_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic row_t rand_row();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom & $urandom;
            2: return $urandom & $urandom & $urandom;
            3: return $urandom | $urandom;
            default: return ($urandom_range(0, 1) != 0) ? '1 : row_t'(1) << $urandom_range(0, 31);
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_beat(func_t'(s_tuser), s_tdata[3:0], s_tdata[35:4]);
            if (m_tvalid && m_tready)
                sb.check_row(m_tdata[3:0], m_tdata[35:4], m_tuser, m_tlast);
        end
    end

    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            else if (stall == 0)
                stall = gap_len();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic sender_idle(int n);
        if (n > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_beat(func_t func, ridx_t idx, row_t cells);
        sender_idle(gap_len());
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(IN_W - 36){1'b0}}, cells, idx};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        items++;
    endtask

    task automatic send_advance();
        send_beat(FUNC_ADVANCE, ridx_t'($urandom), row_t'($urandom));
    endtask

    task automatic wait_emitted();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_rows.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int episode;
        int kind;
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty grid stays empty
        send_advance();
        // full rows 0 and 15 meet across the vertical wrap
        send_beat(FUNC_WRITE, 4'd0, 32'hFFFF_FFFF);
        send_beat(FUNC_WRITE, 4'd15, 32'hFFFF_FFFF);
        send_advance();
        send_beat(FUNC_WRITE, 4'd1, 32'h0000_0000);
        send_beat(FUNC_WRITE, 4'd14, 32'h0000_0000);
        // blinker across the column wrap
        send_beat(FUNC_WRITE, 4'd1, 32'h8000_0003);
        send_advance();
        send_advance();
        send_beat(FUNC_WRITE, 4'd1, 32'h0000_0000);
        // still block on the corner of the torus
        send_beat(FUNC_WRITE, 4'd15, 32'h8000_0001);
        send_beat(FUNC_WRITE, 4'd0, 32'h8000_0001);
        send_advance();
        send_advance();
        // single cell dies, dense rows crowd out
        send_beat(FUNC_WRITE, 4'd7, 32'h0001_0000);
        send_beat(FUNC_WRITE, 4'd8, 32'h5555_AAAA);
        send_beat(FUNC_WRITE, 4'd9, 32'hAAAA_5555);
        send_advance();

        episode = 0;
        while (items < ITEM_COUNT)
        begin
            episode++;
            quiet = (episode % 9 == 4);
            kind  = $urandom_range(0, 9);
            if (episode == 6)
            begin
                // stall the output for a long stretch while input keeps coming
                quiet    = 1'b1;
                hold_req = 1'b1;
                send_advance();
                repeat (4) send_beat(FUNC_WRITE, ridx_t'($urandom), rand_row());
                send_advance();
            end
            else if (episode == 12)
            begin
                wait_emitted();
                send_advance();
            end
            else if (kind < 8)
            begin
                repeat ($urandom_range(1, 6))
                    send_beat(FUNC_WRITE, ridx_t'($urandom), rand_row());
                repeat ($urandom_range(1, 3))
                    send_advance();
            end
            else
                send_beat(func_t'($urandom_range(0, 1)), ridx_t'($urandom), row_t'($urandom));
        end
        quiet = 1'b0;

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_emitted();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending_rows.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
